/* hdl/hwd_pkg.sv */
`default_nettype none

package hwd_pkg;

    // Default widths of positions and timestamps
    localparam int POS_WIDTH_DEF  = 16;
    localparam int TIME_WIDTH_DEF = 32;

    // Configuration field widths
    localparam int THR_W      = 16;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Second-difference magnitude, saturated to MAG_MAX
    localparam int MAG_W   = 17;
    localparam int MAG_MAX = 65536;
    localparam int SQ_W    = 33;
    localparam int SUM_W   = 35;
    localparam int THR_SQ_W = 2 * THR_W;

    // Axes per frame: right x/y/z then left x/y/z
    localparam int NUM_AXES = 6;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic              ENABLE_RST    = 1'b1;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd20;
    localparam logic [HOLD_W-1:0] APPEAR_RST    = 16'd1000;
    localparam logic [HOLD_W-1:0] DISAPPEAR_RST = 16'd2000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_APPEAR    = 2'd2,
        REG_DISAPPEAR = 2'd3
    } hwd_reg_t;

    // Configuration as seen by front and back
    typedef struct packed {
        logic              enable;
        logic [THR_W-1:0]  threshold;
        logic [HOLD_W-1:0] appear_hold;
        logic [HOLD_W-1:0] disappear_hold;
    } hwd_cfg_t;

    typedef logic [MAG_W-1:0] hwd_mag_t;

endpackage

`default_nettype wire

/* hdl/hand_waving_detector.sv */
// Path: an accepted frame passes the queue write, square stage and output
// register in that order. Throughput: one frame per cycle while neither side
// stalls; a two-entry queue decouples the history front end from the squaring
// and hold back end, so either side may stall.
// Reset: configuration returns to its defaults, visibility history, waving
// state and last-wave time clear at once; no clearing pass is needed.
`default_nettype none

module hand_waving_detector #(
    parameter int POS_WIDTH  = hwd_pkg::POS_WIDTH_DEF,
    parameter int TIME_WIDTH = hwd_pkg::TIME_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 agent_tracked,
    input  wire                                 agent_visible,
    input  wire  [TIME_WIDTH-1:0]               time_ms,
    input  wire  signed [POS_WIDTH-1:0]         right_x,
    input  wire  signed [POS_WIDTH-1:0]         right_y,
    input  wire  signed [POS_WIDTH-1:0]         right_z,
    input  wire  signed [POS_WIDTH-1:0]         left_x,
    input  wire  signed [POS_WIDTH-1:0]         left_y,
    input  wire  signed [POS_WIDTH-1:0]         left_z,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic                                waving_now,
    output logic                                right_waving,
    output logic                                left_waving,
    output logic                                waving_active,
    output logic                                start_event,
    output logic                                stop_event,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [hwd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [hwd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hwd_pkg::*;

    localparam int ENTRY_W = 2 + TIME_WIDTH + NUM_AXES * MAG_W;

    hwd_cfg_t         cfg_reg, cfg_next;
    logic             push;
    logic [ENTRY_W-1:0] push_data;
    logic             full;
    logic             pop;
    logic [ENTRY_W-1:0] pop_data;
    logic             empty;

    assign cfg_ready = 1'b1;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (hwd_reg_t'(cfg_index))
                REG_ENABLE:    cfg_next.enable         = cfg_data[0];
                REG_THRESHOLD: cfg_next.threshold      = cfg_data[THR_W-1:0];
                REG_APPEAR:    cfg_next.appear_hold    = cfg_data[HOLD_W-1:0];
                REG_DISAPPEAR: cfg_next.disappear_hold = cfg_data[HOLD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable         <= ENABLE_RST;
            cfg_reg.threshold      <= THRESHOLD_RST;
            cfg_reg.appear_hold    <= APPEAR_RST;
            cfg_reg.disappear_hold <= DISAPPEAR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hwd_front #(
        .POS_WIDTH  (POS_WIDTH),
        .TIME_WIDTH (TIME_WIDTH),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .agent_tracked (agent_tracked),
        .agent_visible (agent_visible),
        .time_ms       (time_ms),
        .right_x       (right_x),
        .right_y       (right_y),
        .right_z       (right_z),
        .left_x        (left_x),
        .left_y        (left_y),
        .left_z        (left_z),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    hwd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    hwd_back #(
        .TIME_WIDTH (TIME_WIDTH),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_data      (pop_data),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .waving_now    (waving_now),
        .right_waving  (right_waving),
        .left_waving   (left_waving),
        .waving_active (waving_active),
        .start_event   (start_event),
        .stop_event    (stop_event)
    );

endmodule

`default_nettype wire

/* hdl/hwd_fifo.sv */
`default_nettype none

module hwd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire  [WIDTH-1:0]   push_data,
    output logic               full,
    input  wire                pop,
    output logic [WIDTH-1:0]   pop_data,
    output logic               empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/hwd_front.sv */
`default_nettype none

module hwd_front #(
    parameter int POS_WIDTH  = 16,
    parameter int TIME_WIDTH = 32,
    parameter int ENTRY_W    = 136
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  hwd_pkg::hwd_cfg_t       cfg,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire                           agent_tracked,
    input  wire                           agent_visible,
    input  wire  [TIME_WIDTH-1:0]         time_ms,
    input  wire  signed [POS_WIDTH-1:0]   right_x,
    input  wire  signed [POS_WIDTH-1:0]   right_y,
    input  wire  signed [POS_WIDTH-1:0]   right_z,
    input  wire  signed [POS_WIDTH-1:0]   left_x,
    input  wire  signed [POS_WIDTH-1:0]   left_y,
    input  wire  signed [POS_WIDTH-1:0]   left_z,
    output logic                          push,
    output logic [ENTRY_W-1:0]            push_data,
    input  wire                           full
);
    import hwd_pkg::*;

    localparam int DW = POS_WIDTH + 2;
    localparam int CW = (DW > MAG_W + 1) ? DW : MAG_W + 1;

    logic [POS_WIDTH-1:0] cur      [NUM_AXES];
    logic [POS_WIDTH-1:0] prev_reg [NUM_AXES];
    logic [POS_WIDTH-1:0] prev_next[NUM_AXES];
    logic [POS_WIDTH-1:0] prev2_reg [NUM_AXES];
    logic [POS_WIDTH-1:0] prev2_next[NUM_AXES];
    logic                 seen_last_reg, seen_last_next;
    logic                 seen_before_reg, seen_before_next;
    logic [DW-1:0]        diff [NUM_AXES];
    logic [DW-1:0]        mag  [NUM_AXES];
    logic [NUM_AXES-1:0][MAG_W-1:0] sat;
    logic                 accept;
    logic                 live;
    logic                 act;

    assign cur[0] = right_x;
    assign cur[1] = right_y;
    assign cur[2] = right_z;
    assign cur[3] = left_x;
    assign cur[4] = left_y;
    assign cur[5] = left_z;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign push     = accept;
    assign live     = cfg.enable && agent_tracked;
    assign act      = live && agent_visible;

    // Second difference per axis, magnitude saturated at MAG_MAX
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            diff[i] = {{2{cur[i][POS_WIDTH-1]}}, cur[i]}
                    - {prev_reg[i][POS_WIDTH-1], prev_reg[i], 1'b0}
                    + {{2{prev2_reg[i][POS_WIDTH-1]}}, prev2_reg[i]};
            mag[i]  = diff[i][DW-1] ? (~diff[i] + 1'b1) : diff[i];
            sat[i]  = (CW'(mag[i]) > CW'(MAG_MAX)) ? MAG_W'(MAG_MAX)
                                                    : MAG_W'(CW'(mag[i]));
        end
    end

    assign push_data = {act, seen_last_reg && seen_before_reg, time_ms, sat};

    // Shift history on each tracked frame while the detector is enabled
    always_comb
    begin
        prev_next        = prev_reg;
        prev2_next       = prev2_reg;
        seen_last_next   = seen_last_reg;
        seen_before_next = seen_before_reg;
        if (accept && live)
        begin
            seen_before_next = seen_last_reg;
            seen_last_next   = agent_visible;
            if (agent_visible)
            begin
                prev2_next = prev_reg;
                prev_next  = cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_last_reg   <= 1'b0;
            seen_before_reg <= 1'b0;
        end
        else
        begin
            seen_last_reg   <= seen_last_next;
            seen_before_reg <= seen_before_next;
        end
    end

    // Position history is only read after two visible frames have filled it
    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        prev2_reg <= prev2_next;
    end

endmodule

`default_nettype wire

/* hdl/hwd_back.sv */
`default_nettype none

module hwd_back #(
    parameter int TIME_WIDTH = 32,
    parameter int ENTRY_W    = 136
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  hwd_pkg::hwd_cfg_t  cfg,
    input  wire  [ENTRY_W-1:0]       pop_data,
    input  wire                      empty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire                      out_stall,
    output logic                     waving_now,
    output logic                     right_waving,
    output logic                     left_waving,
    output logic                     waving_active,
    output logic                     start_event,
    output logic                     stop_event
);
    import hwd_pkg::*;

    localparam int PROD_W = 2 * MAG_W;

    logic                              e_act;
    logic                              e_qual;
    logic [TIME_WIDTH-1:0]             e_time;
    logic [NUM_AXES-1:0][MAG_W-1:0]    e_mag;

    logic                  a_valid_reg, a_valid_next;
    logic                  a_act_reg, a_act_next;
    logic                  a_qual_reg, a_qual_next;
    logic [TIME_WIDTH-1:0] a_time_reg, a_time_next;
    logic [SQ_W-1:0]       a_sq_reg [NUM_AXES];
    logic [SQ_W-1:0]       a_sq_next[NUM_AXES];
    logic [PROD_W-1:0]     prod [NUM_AXES];
    logic [THR_SQ_W-1:0]   thr_sq_reg, thr_sq_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  wn_reg, wn_next;
    logic                  rw_reg, rw_next;
    logic                  lw_reg, lw_next;
    logic                  st_reg, st_next;
    logic                  sp_reg, sp_next;
    logic                  waving_flag_reg, waving_flag_next;
    logic [TIME_WIDTH-1:0] last_wave_reg, last_wave_next;
    logic                  wave_valid_reg, wave_valid_next;

    logic                  b_ready;
    logic                  a_ready;
    logic [SUM_W-1:0]      sum_r;
    logic [SUM_W-1:0]      sum_l;
    logic                  r_over;
    logic                  l_over;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  pass_app;
    logic                  pass_dis;
    logic                  rw;
    logic                  lw;
    logic                  wn;
    logic                  st;
    logic                  sp;

    assign {e_act, e_qual, e_time, e_mag} = pop_data;

    // Handshake between queue, square stage and output register
    assign b_ready = !out_valid_reg || !out_stall;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = !empty && a_ready;

    // Square stage
    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_act_next   = a_act_reg;
        a_qual_next  = a_qual_reg;
        a_time_next  = a_time_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            prod[i]      = PROD_W'(e_mag[i]) * PROD_W'(e_mag[i]);
            a_sq_next[i] = a_sq_reg[i];
        end
        if (a_ready)
        begin
            a_valid_next = !empty;
        end
        if (pop)
        begin
            a_act_next  = e_act;
            a_qual_next = e_qual;
            a_time_next = e_time;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                a_sq_next[i] = SQ_W'(prod[i]);
            end
        end
        thr_sq_next = THR_SQ_W'(cfg.threshold) * THR_SQ_W'(cfg.threshold);
    end

    // Compare norms and run the hold logic
    always_comb
    begin
        sum_r    = SUM_W'(a_sq_reg[0]) + SUM_W'(a_sq_reg[1]) + SUM_W'(a_sq_reg[2]);
        sum_l    = SUM_W'(a_sq_reg[3]) + SUM_W'(a_sq_reg[4]) + SUM_W'(a_sq_reg[5]);
        r_over   = sum_r > SUM_W'(thr_sq_reg);
        l_over   = sum_l > SUM_W'(thr_sq_reg);
        rw       = a_act_reg && a_qual_reg && r_over;
        lw       = a_act_reg && a_qual_reg && l_over;
        wn       = rw || lw;
        elapsed  = a_time_reg - last_wave_reg;
        pass_app = !wave_valid_reg || (elapsed > TIME_WIDTH'(cfg.appear_hold));
        pass_dis = !wave_valid_reg || (elapsed > TIME_WIDTH'(cfg.disappear_hold));
        st       = a_act_reg && pass_app && !waving_flag_reg && wn;
        sp       = a_act_reg && pass_dis && waving_flag_reg && !wn;
    end

    // Output register and held waving state
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        wn_next          = wn_reg;
        rw_next          = rw_reg;
        lw_next          = lw_reg;
        st_next          = st_reg;
        sp_next          = sp_reg;
        waving_flag_next = waving_flag_reg;
        last_wave_next   = last_wave_reg;
        wave_valid_next  = wave_valid_reg;
        if (b_ready)
        begin
            out_valid_next = a_valid_reg;
            if (a_valid_reg)
            begin
                wn_next = wn;
                rw_next = rw;
                lw_next = lw;
                st_next = st;
                sp_next = sp;
                if (st)
                begin
                    waving_flag_next = 1'b1;
                end
                if (sp)
                begin
                    waving_flag_next = 1'b0;
                end
                if (wn)
                begin
                    last_wave_next  = a_time_reg;
                    wave_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            wn_reg          <= 1'b0;
            rw_reg          <= 1'b0;
            lw_reg          <= 1'b0;
            st_reg          <= 1'b0;
            sp_reg          <= 1'b0;
            waving_flag_reg <= 1'b0;
            last_wave_reg   <= '0;
            wave_valid_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= a_valid_next;
            out_valid_reg   <= out_valid_next;
            wn_reg          <= wn_next;
            rw_reg          <= rw_next;
            lw_reg          <= lw_next;
            st_reg          <= st_next;
            sp_reg          <= sp_next;
            waving_flag_reg <= waving_flag_next;
            last_wave_reg   <= last_wave_next;
            wave_valid_reg  <= wave_valid_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        a_act_reg  <= a_act_next;
        a_qual_reg <= a_qual_next;
        a_time_reg <= a_time_next;
        a_sq_reg   <= a_sq_next;
        thr_sq_reg <= thr_sq_next;
    end

    assign out_valid     = out_valid_reg;
    assign waving_now    = wn_reg;
    assign right_waving  = rw_reg;
    assign left_waving   = lw_reg;
    assign waving_active = waving_flag_reg;
    assign start_event   = st_reg;
    assign stop_event    = sp_reg;

    // A start leaves the state on, a stop leaves it off
    a_start_sets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && st_reg |-> waving_flag_reg)
        else $error("start event without waving state");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sp_reg |-> !waving_flag_reg)
        else $error("stop event with waving state still on");

    // The held state moves only together with a reported event
    a_rise_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(waving_flag_reg) |-> out_valid_reg && st_reg)
        else $error("waving state rose without start event");

    a_fall_has_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(waving_flag_reg) |-> out_valid_reg && sp_reg)
        else $error("waving state fell without stop event");

endmodule

`default_nettype wire

/* bench/tb_hand_waving_detector.sv */
`timescale 1ns / 1ps

module tb_hand_waving_detector;
    import hwd_pkg::*;

    localparam int POS_W       = POS_WIDTH_DEF;
    localparam int TIME_W      = TIME_WIDTH_DEF;
    localparam int PMAX        = 32767;
    localparam int PMIN        = -32768;
    localparam int CYCLE_LIMIT = 200000;

    // One tracking frame; axes are right x/y/z then left x/y/z
    typedef struct {
        logic                    tracked;
        logic                    visible;
        logic [TIME_W-1:0]       stamp;
        logic signed [POS_W-1:0] axis [6];
    } frame_t;

    // Result flags, waving_now in the top bit
    typedef struct packed {
        logic waving_now;
        logic right_waving;
        logic left_waving;
        logic waving_active;
        logic start_event;
        logic stop_event;
    } flags_t;

    // Tracks the detector state and holds the flags each accepted frame must produce
    class wave_scoreboard;
        hwd_cfg_t                cfg;
        logic signed [POS_W-1:0] hist1 [6];
        logic signed [POS_W-1:0] hist2 [6];
        bit                      seen1;
        bit                      seen2;
        bit                      held;
        bit                      stamp_ok;
        logic [TIME_W-1:0]       last_wave;
        flags_t                  expected_flags [$];
        int                      errors;
        int                      frames;
        int                      checked;
        int                      starts;
        int                      stops;

        function new();
            int i;
            cfg.enable         = ENABLE_RST;
            cfg.threshold      = THRESHOLD_RST;
            cfg.appear_hold    = APPEAR_RST;
            cfg.disappear_hold = DISAPPEAR_RST;
            for (i = 0; i < 6; i++)
            begin
                hist1[i] = '0;
                hist2[i] = '0;
            end
            seen1     = 0;
            seen2     = 0;
            held      = 0;
            stamp_ok  = 0;
            last_wave = '0;
            errors    = 0;
            frames    = 0;
            checked   = 0;
            starts    = 0;
            stops     = 0;
        endfunction

        function void apply_reg(hwd_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLE:    cfg.enable         = data[0];
                REG_THRESHOLD: cfg.threshold      = data;
                REG_APPEAR:    cfg.appear_hold    = data;
                REG_DISAPPEAR: cfg.disappear_hold = data;
                default:       ;
            endcase
        endfunction

        // Squared norm of the second difference against the squared threshold
        function bit hand_moved(frame_t f, int first);
            longint sum;
            longint a;
            longint thr;
            int     i;
            sum = 0;
            for (i = first; i < first + 3; i++)
            begin
                a = longint'(f.axis[i]) - 2 * longint'(hist1[i]) + longint'(hist2[i]);
                if (a < 0)
                    a = -a;
                if (a > longint'(MAG_MAX))
                    a = longint'(MAG_MAX);
                sum += a * a;
            end
            thr = longint'(cfg.threshold);
            return sum > thr * thr;
        endfunction

        function void note_frame(frame_t f);
            flags_t            want;
            logic [TIME_W-1:0] elapsed;
            bit                pass_app;
            bit                pass_dis;
            int                i;
            want = '0;
            frames++;
            if (cfg.enable && f.tracked)
            begin
                if (!f.visible)
                begin
                    // shift a miss into the visibility history
                    seen2 = seen1;
                    seen1 = 0;
                end
                else
                begin
                    want.right_waving = hand_moved(f, 0) && seen1 && seen2;
                    want.left_waving  = hand_moved(f, 3) && seen1 && seen2;
                    want.waving_now   = want.right_waving || want.left_waving;
                    for (i = 0; i < 6; i++)
                    begin
                        hist2[i] = hist1[i];
                        hist1[i] = f.axis[i];
                    end
                    // hold times pass outright until the first wave
                    elapsed  = f.stamp - last_wave;
                    pass_app = !stamp_ok || elapsed > TIME_W'(cfg.appear_hold);
                    pass_dis = !stamp_ok || elapsed > TIME_W'(cfg.disappear_hold);
                    want.start_event = pass_app && !held && want.waving_now;
                    want.stop_event  = pass_dis && held && !want.waving_now;
                    if (want.start_event)
                        held = 1;
                    if (want.stop_event)
                        held = 0;
                    if (want.waving_now)
                    begin
                        last_wave = f.stamp;
                        stamp_ok  = 1;
                    end
                    seen2 = seen1;
                    seen1 = 1;
                end
            end
            want.waving_active = held;
            expected_flags.push_back(want);
        endfunction

        function void check_flags(flags_t got);
            flags_t want;
            string  names [6] = '{"stop_event", "start_event", "waving_active",
                                  "left_waving", "right_waving", "waving_now"};
            int     i;
            if (expected_flags.size() == 0)
            begin
                errors++;
                $display("%0t ns: result transfer with no frame pending, actual %b",
                         $time, got);
                return;
            end
            want = expected_flags.pop_front();
            checked++;
            starts += int'(got.start_event);
            stops  += int'(got.stop_event);
            for (i = 0; i < 6; i++)
            begin
                if (got[i] !== want[i])
                begin
                    errors++;
                    $display("%0t ns: %s mismatch, expected %b, actual %b",
                             $time, names[i], want[i], got[i]);
                end
            end
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    agent_tracked = 1'b0;
    logic                    agent_visible = 1'b0;
    logic [TIME_W-1:0]       time_ms = '0;
    logic signed [POS_W-1:0] right_x = '0;
    logic signed [POS_W-1:0] right_y = '0;
    logic signed [POS_W-1:0] right_z = '0;
    logic signed [POS_W-1:0] left_x = '0;
    logic signed [POS_W-1:0] left_y = '0;
    logic signed [POS_W-1:0] left_z = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    waving_now;
    logic                    right_waving;
    logic                    left_waving;
    logic                    waving_active;
    logic                    start_event;
    logic                    stop_event;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    wave_scoreboard sb = new();
    int             tracked_sent = 0;
    int             settings_used = 0;
    int             cycle_count = 0;
    bit             sender_steady = 0;
    bit             stall_calm = 0;

    hand_waving_detector u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .agent_tracked (agent_tracked),
        .agent_visible (agent_visible),
        .time_ms       (time_ms),
        .right_x       (right_x),
        .right_y       (right_y),
        .right_z       (right_z),
        .left_x        (left_x),
        .left_y        (left_y),
        .left_z        (left_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .waving_now    (waving_now),
        .right_waving  (right_waving),
        .left_waving   (left_waving),
        .waving_active (waving_active),
        .start_event   (start_event),
        .stop_event    (stop_event),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("tb_hand_waving_detector failed");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_flags({waving_now, right_waving, left_waving,
                            waving_active, start_event, stop_event});
    end

    // Stall the result side a random number of cycles before each transfer
    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = stall_calm ? 0 : $urandom_range(0, 5);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            if ($urandom_range(0, 29) == 0)
                stall_calm = !stall_calm;
        end
    end

    // Present one frame after a random gap and hold it until the transfer
    task automatic send_frame(frame_t f);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        agent_tracked <= f.tracked;
        agent_visible <= f.visible;
        time_ms       <= f.stamp;
        right_x       <= f.axis[0];
        right_y       <= f.axis[1];
        right_z       <= f.axis[2];
        left_x        <= f.axis[3];
        left_y        <= f.axis[4];
        left_z        <= f.axis[5];
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_frame(f);
        tracked_sent += int'(f.tracked);
    endtask

    // Drop valid and wait out every outstanding result
    task automatic drain_results();
        if (sb.pending() != 0)
        begin
            in_valid <= 1'b0;
            while (sb.pending() != 0)
                @(posedge clk);
        end
    endtask

    task automatic cfg_write(hwd_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_reg(idx, data);
    endtask

    // Reprogram all registers while the block is idle
    task automatic set_config(logic en, logic [CFG_DATA_W-1:0] thr,
                              logic [CFG_DATA_W-1:0] app, logic [CFG_DATA_W-1:0] dis);
        drain_results();
        cfg_write(REG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
        cfg_write(REG_THRESHOLD, thr);
        cfg_write(REG_APPEAR, app);
        cfg_write(REG_DISAPPEAR, dis);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic frame_t make_frame(logic tr, logic vis, logic [TIME_W-1:0] stamp,
                                          int rx, int ry, int rz, int lx, int ly, int lz);
        frame_t f;
        f.tracked = tr;
        f.visible = vis;
        f.stamp   = stamp;
        f.axis[0] = POS_W'(rx);
        f.axis[1] = POS_W'(ry);
        f.axis[2] = POS_W'(rz);
        f.axis[3] = POS_W'(lx);
        f.axis[4] = POS_W'(ly);
        f.axis[5] = POS_W'(lz);
        return f;
    endfunction

    // Mostly visible runs of still or oscillating hands, with some noise frames
    task automatic run_phase(int budget, int step_max);
        frame_t            f;
        int                target;
        int                len;
        int                k;
        int                i;
        int                amax;
        bit                move_r;
        bit                move_l;
        int                amp [6];
        int                base [6];
        logic [TIME_W-1:0] stamp;
        target = tracked_sent + budget;
        stamp  = $urandom();
        amax   = sb.cfg.threshold / 2 + 3;
        if (amax > 16000)
            amax = 16000;
        while (tracked_sent < target)
        begin
            sender_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) == 0)
                drain_results();
            if ($urandom_range(0, 9) == 0)
            begin
                // full-range noise frame
                f.tracked = 1'($urandom());
                f.visible = 1'($urandom());
                f.stamp   = $urandom();
                for (i = 0; i < 6; i++)
                    f.axis[i] = POS_W'($urandom());
                send_frame(f);
            end
            else
            begin
                len    = $urandom_range(3, 12);
                move_r = 1'($urandom_range(0, 1));
                move_l = 1'($urandom_range(0, 1));
                for (i = 0; i < 6; i++)
                begin
                    base[i] = $urandom_range(0, 32767) - 16384;
                    amp[i]  = ((i < 3) ? move_r : move_l) ? $urandom_range(0, amax) : 0;
                end
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 39) == 0)
                        stamp = $urandom();
                    else
                        stamp += $urandom_range(0, step_max);
                    f.tracked = 1'b1;
                    f.visible = 1'b1;
                    case ($urandom_range(0, 11))
                        0:       f.visible = 1'b0;
                        1:       f.tracked = 1'b0;
                        default: ;
                    endcase
                    f.stamp = stamp;
                    for (i = 0; i < 6; i++)
                        f.axis[i] = POS_W'(base[i] + ((k % 2) ? amp[i] : -amp[i])
                                           + $urandom_range(0, 4) - 2);
                    send_frame(f);
                end
            end
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_FC00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames on reset settings; timestamps cross the wrap
        send_frame(make_frame(0, 1, t0, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
        send_frame(make_frame(1, 0, t0 + 10, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(1, 1, t0 + 20, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(1, 1, t0 + 30, 0, 0, 0, 0, 0, 0));
        // squared norm exactly at threshold squared on the right, one above it on the left
        send_frame(make_frame(1, 1, t0 + 40, 12, 16, 0, 12, 16, 1));
        send_frame(make_frame(1, 1, t0 + 50, 24, 32, 0, 24, 32, 2));
        // full-scale swings saturate the second difference
        send_frame(make_frame(1, 1, t0 + 60, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
        send_frame(make_frame(1, 1, t0 + 70, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX));
        send_frame(make_frame(1, 1, t0 + 80, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
        send_frame(make_frame(1, 1, t0 + 100, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
        // quiet time equal to the stop hold, then one past it
        send_frame(make_frame(1, 1, t0 + 2100, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
        send_frame(make_frame(1, 1, t0 + 2101, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
        send_frame(make_frame(1, 1, t0 + 2300, 0, 0, 0, PMIN, PMIN, PMIN));
        send_frame(make_frame(0, 0, t0 + 2350, 1234, -1234, 99, -99, 7, -7));
        send_frame(make_frame(1, 1, t0 + 2400, 0, 0, 0, PMIN, PMIN, PMIN));
        send_frame(make_frame(1, 1, t0 + 2500, 0, 0, 0, PMIN, PMIN, PMIN));
        // a miss breaks the history for the next two visible frames
        send_frame(make_frame(1, 0, t0 + 2600, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(1, 1, t0 + 2700, 5000, 5000, 5000, PMIN, PMIN, PMIN));
        send_frame(make_frame(1, 1, t0 + 2800, -5000, -5000, -5000, PMIN, PMIN, PMIN));
        send_frame(make_frame(1, 1, t0 + 2900, 5000, 5000, 5000, PMIN, PMIN, PMIN));

        // Random phases, one per register setting
        set_config(1'b1, THRESHOLD_RST, APPEAR_RST, DISAPPEAR_RST);
        run_phase(150, 400);
        set_config(1'b1, '0, '0, '0);
        run_phase(120, 3);
        set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(120, 30000);
        set_config(1'b0, CFG_DATA_W'($urandom_range(0, 100)),
                   CFG_DATA_W'($urandom_range(0, 2000)),
                   CFG_DATA_W'($urandom_range(0, 2000)));
        run_phase(60, 500);
        set_config(1'b1, CFG_DATA_W'($urandom_range(20, 300)),
                   CFG_DATA_W'($urandom_range(1500, 3000)),
                   CFG_DATA_W'($urandom_range(200, 800)));
        run_phase(140, 400);
        set_config(1'b1, CFG_DATA_W'($urandom_range(0, 40)),
                   CFG_DATA_W'($urandom_range(0, 5)),
                   CFG_DATA_W'($urandom_range(0, 5)));
        run_phase(130, 6);

        drain_results();
        repeat (4) @(posedge clk);
        $display("Sent %0d frames over %0d register settings; checked %0d results",
                 sb.frames, settings_used, sb.checked);
        $display("Saw %0d waving starts and %0d stops; %0d mismatches",
                 sb.starts, sb.stops, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_hand_waving_detector passed");
        else
            $display("tb_hand_waving_detector failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hwd_pkg.sv
hdl/hwd_fifo.sv
hdl/hwd_front.sv
hdl/hwd_back.sv
hdl/hand_waving_detector.sv
bench/tb_hand_waving_detector.sv
